// ===== src/particle_pool_euler_update_top_assert.svh =====
// Assertion macros shared by the particle pool RTL.
`ifndef PARTICLE_POOL_EULER_UPDATE_TOP_ASSERT_SVH
`define PARTICLE_POOL_EULER_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPEU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ppeu_pkg.sv =====
package ppeu_pkg;

    localparam int MaxParticles = 64;
    localparam int AddrW        = $clog2(MaxParticles);
    localparam int CntW         = $clog2(MaxParticles + 1);
    localparam int InDataW      = 296;
    localparam int OutDataW     = 144;

    localparam logic signed [31:0] Grav   = -32'sd642908;
    localparam logic signed [31:0] FloorY = 32'sd655;
    localparam logic signed [31:0] Bounce = -32'sd26214;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [23:0]        rgb;
        logic signed [31:0] life;
        logic [30:0]        mlife;
        logic [15:0]        size;
    } t_rec;

    localparam int RecW = $bits(t_rec);

    typedef struct packed {
        logic        start;
        logic [30:0] life;
        logic [30:0] mlife;
    } t_div_req;

    // floor(p / 65536), saturated to 32-bit signed
    function automatic logic signed [31:0] f_qsat(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 16;
        if (s > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (s < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return $signed(s[31:0]);
    endfunction

    function automatic logic signed [31:0] f_add_sat(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh80000000 : 32'sh7fffffff;
        end
        return $signed(s[31:0]);
    endfunction

endpackage

// ===== src/ppeu_ram.sv =====
module ppeu_ram #(
    parameter int Depth = 64,
    parameter int Width = 8,
    parameter int AddrW = $clog2(Depth)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== src/ppeu_alpha.sv =====
module ppeu_alpha (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppeu_pkg::t_div_req i_req,
    output logic               o_done,
    output logic [7:0]         o_alpha
);

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_k;
    logic [38:0] r_rem;
    logic [30:0] r_den;
    logic [7:0]  r_q;
    logic [38:0] w_shift;
    logic [39:0] w_trial;
    logic        w_fit;

    assign w_shift = 39'(r_den) << r_k;
    assign w_trial = {1'b0, r_rem} - {1'b0, w_shift};
    assign w_fit   = !w_trial[39];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_k == 3'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == 3'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // restoring division of 255*life by max_life, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= 39'({i_req.life, 8'b0}) - 39'(i_req.life);
            r_den <= i_req.mlife;
            r_k   <= 3'd7;
            r_q   <= 8'd0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= w_trial[38:0];
            end
            r_q[r_k] <= w_fit;
            r_k      <= r_k - 3'd1;
        end
    end

    assign o_done  = r_done;
    assign o_alpha = r_q;

endmodule

// ===== src/particle_pool_euler_update_top.sv =====
// Particle pool with Euler integration in signed Q16.16.
// Input stream s_*: one request per item; s_tuser is the opcode (0 emit, 1 update).
// An emit request writes the particle at slot live_count,
// or is dropped when the pool is full. It gives no output.
// An update request runs three passes over the record memory, one slot at a time:
//   integrate: per live particle read, latch, six multiply steps, write,
//   compact:   read, latch and check per slot, plus copy and reload per dead particle moved by swap-with-last,
//   output:    per survivor read, latch, 8 divider steps, wait for the divider's done,
//              load.
// The record memory has one read and one write port, and one 32x32 multiplier is
// shared by all integration steps. s_tready is high only while idle.
// Output stream m_*: one request per survivor in slot order, m_tlast on the last.
// The output register holds a result while m_tready is low; the output pass waits
// on it, and an idle block takes new requests while the last result waits.
// Reset empties the pool (live_count = 0); the memory is not cleared and needs no pass.
module particle_pool_euler_update_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_x, start_y, start_z, speed_x, speed_y, speed_z, tint_rgba,
    // lifetime, point_size, time_step, zero pad
    input  logic [ppeu_pkg::InDataW-1:0]   s_tdata,
    // opcode
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_x, out_y, out_z, out_rgba, out_size
    output logic [ppeu_pkg::OutDataW-1:0]  m_tdata,
    // last_of_run
    output logic                           m_tlast
);

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_IRD  = 14'b00000000000010,
        ST_ILD  = 14'b00000000000100,
        ST_IMUL = 14'b00000000001000,
        ST_IWR  = 14'b00000000010000,
        ST_CRD  = 14'b00000000100000,
        ST_CLD  = 14'b00000001000000,
        ST_CCHK = 14'b00000010000000,
        ST_CCPY = 14'b00000100000000,
        ST_CCLD = 14'b00001000000000,
        ST_ORD  = 14'b00010000000000,
        ST_OLD  = 14'b00100000000000,
        ST_ODIV = 14'b01000000000000,
        ST_OOUT = 14'b10000000000000
    } t_state;

    localparam int AW = ppeu_pkg::AddrW;
    localparam int CW = ppeu_pkg::CntW;

    t_state                         r_state, n_state;
    logic [CW-1:0]                  r_cnt;
    logic [CW-1:0]                  r_idx;
    logic [20:0]                    r_dt;
    ppeu_pkg::t_rec                 r_rec;
    logic signed [63:0]             r_prod;
    logic [2:0]                     r_step;
    logic                           r_m_valid;
    logic [ppeu_pkg::OutDataW-1:0]  r_m_data;
    logic                           r_m_last;

    logic                           in_acc;
    logic                           w_opc;
    logic                           w_full;
    ppeu_pkg::t_rec                 w_emit;
    ppeu_pkg::t_rec                 w_rd;
    logic [ppeu_pkg::RecW-1:0]      w_rdata;
    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    logic [ppeu_pkg::RecW-1:0]      w_wdata;
    logic [AW-1:0]                  w_raddr;
    logic [CW-1:0]                  w_idx_inc;
    logic [CW-1:0]                  w_cnt_dec;
    logic signed [31:0]             w_dt32;
    logic signed [31:0]             w_mul_a;
    logic signed [31:0]             w_mul_b;
    logic signed [63:0]             w_prod;
    logic signed [31:0]             w_q;
    logic                           w_out_load;
    logic                           w_is_last;
    ppeu_pkg::t_div_req             w_div_req;
    logic                           w_div_done;
    logic [7:0]                     w_alpha;

    assign s_tready  = (r_state == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign w_opc     = s_tuser[0];
    assign w_full    = (r_cnt >= CW'(ppeu_pkg::MaxParticles));
    assign w_idx_inc = r_idx + CW'(1);
    assign w_cnt_dec = r_cnt - CW'(1);
    assign w_dt32    = $signed({11'b0, r_dt});
    assign w_rd      = ppeu_pkg::t_rec'(w_rdata);
    assign w_is_last = (w_idx_inc == r_cnt);
    assign w_out_load = (r_state == ST_OOUT) && (!r_m_valid || m_tready);

    always_comb begin
        w_emit.px    = $signed(s_tdata[31:0]);
        w_emit.py    = $signed(s_tdata[63:32]);
        w_emit.pz    = $signed(s_tdata[95:64]);
        w_emit.vx    = $signed(s_tdata[127:96]);
        w_emit.vy    = $signed(s_tdata[159:128]);
        w_emit.vz    = $signed(s_tdata[191:160]);
        w_emit.rgb   = s_tdata[223:200];
        w_emit.life  = $signed({1'b0, s_tdata[254:224]});
        w_emit.mlife = s_tdata[254:224];
        w_emit.size  = s_tdata[270:255];
    end

    // memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = w_emit;
        w_raddr = r_idx[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                w_we = in_acc && !w_opc && !w_full;
            end
            ST_IWR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = r_rec;
            end
            ST_CCPY: begin
                w_raddr = w_cnt_dec[AW-1:0];
            end
            ST_CCLD: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = w_rdata;
            end
            default: begin
            end
        endcase
    end

    ppeu_ram #(
        .Depth (ppeu_pkg::MaxParticles),
        .Width (ppeu_pkg::RecW),
        .AddrW (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared multiplier operands per integration step
    always_comb begin
        w_mul_a = ppeu_pkg::Grav;
        w_mul_b = w_dt32;
        unique case (r_step)
            3'd1: w_mul_a = r_rec.vx;
            3'd2: w_mul_a = r_rec.vy;
            3'd3: w_mul_a = r_rec.vz;
            3'd4: begin
                w_mul_a = r_rec.vy;
                w_mul_b = ppeu_pkg::Bounce;
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_q    = ppeu_pkg::f_qsat(r_prod);

    always_comb begin
        w_div_req.start = (r_state == ST_OLD);
        w_div_req.life  = w_rd.life[30:0];
        w_div_req.mlife = w_rd.mlife;
    end

    ppeu_alpha u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_alpha (w_alpha)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && w_opc && r_cnt != CW'(0)) begin
                    n_state = ST_IRD;
                end
            end
            ST_IRD:  n_state = ST_ILD;
            ST_ILD:  n_state = ST_IMUL;
            ST_IMUL: begin
                if (r_step == 3'd5) begin
                    n_state = ST_IWR;
                end
            end
            ST_IWR:  n_state = (w_idx_inc < r_cnt) ? ST_IRD : ST_CRD;
            ST_CRD: begin
                if (r_idx < r_cnt) begin
                    n_state = ST_CLD;
                end else begin
                    n_state = (r_cnt == CW'(0)) ? ST_IDLE : ST_ORD;
                end
            end
            ST_CLD:  n_state = ST_CCHK;
            ST_CCHK: begin
                if (r_rec.life > 0 || r_idx == w_cnt_dec) begin
                    n_state = ST_CRD;
                end else begin
                    n_state = ST_CCPY;
                end
            end
            ST_CCPY: n_state = ST_CCLD;
            ST_CCLD: n_state = ST_CCHK;
            ST_ORD:  n_state = ST_OLD;
            ST_OLD:  n_state = ST_ODIV;
            ST_ODIV: begin
                if (w_div_done) begin
                    n_state = ST_OOUT;
                end
            end
            ST_OOUT: begin
                if (w_out_load) begin
                    n_state = w_is_last ? ST_IDLE : ST_ORD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    if (in_acc && !w_opc && !w_full) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_IWR: begin
                    r_idx <= (w_idx_inc < r_cnt) ? w_idx_inc : CW'(0);
                end
                ST_CRD: begin
                    if (r_idx >= r_cnt) begin
                        r_idx <= '0;
                    end
                end
                ST_CCHK: begin
                    if (r_rec.life > 0) begin
                        r_idx <= w_idx_inc;
                    end else if (r_idx == w_cnt_dec) begin
                        r_cnt <= w_cnt_dec;
                    end
                end
                ST_CCLD: r_cnt <= w_cnt_dec;
                ST_OOUT: begin
                    if (w_out_load) begin
                        r_idx <= w_idx_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // record datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_dt <= s_tdata[291:271];
                end
            end
            ST_ILD: begin
                r_rec  <= w_rd;
                r_step <= 3'd0;
            end
            ST_IMUL: begin
                r_step <= r_step + 3'd1;
                unique case (r_step)
                    3'd0: r_rec.life <= ppeu_pkg::f_add_sat(r_rec.life, 32'sd0 - w_dt32);
                    3'd1: r_rec.vy   <= ppeu_pkg::f_add_sat(r_rec.vy, w_q);
                    3'd2: r_rec.px   <= ppeu_pkg::f_add_sat(r_rec.px, w_q);
                    3'd3: r_rec.py   <= ppeu_pkg::f_add_sat(r_rec.py, w_q);
                    3'd4: r_rec.pz   <= ppeu_pkg::f_add_sat(r_rec.pz, w_q);
                    3'd5: begin
                        // floor hit: clamp y and bounce vertical speed
                        if (r_rec.py < 0) begin
                            r_rec.py <= ppeu_pkg::FloorY;
                            r_rec.vy <= w_q;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_CLD, ST_CCLD, ST_OLD: r_rec <= w_rd;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {r_rec.size, r_rec.rgb, w_alpha, r_rec.pz, r_rec.py, r_rec.px};
            r_m_last <= w_is_last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tlast  = r_m_last;

    `include "particle_pool_euler_update_top_assert.svh"

    `PPEU_ASSERT_NEXT(a_full_drop, in_acc && !w_opc && w_full, $stable(r_cnt), "emit into full pool changed count")
    `PPEU_ASSERT_IMP(a_copy_range, r_state == ST_CCLD, r_idx < w_cnt_dec, "swap copy outside live range")
    `PPEU_ASSERT_IMP(a_out_range, r_state == ST_OOUT, r_idx < r_cnt, "output slot beyond live count")
    `PPEU_ASSERT_NEXT(a_last_idle, w_out_load && w_is_last, r_state == ST_IDLE, "no idle after last survivor")

endmodule
